// ----- hw/rtl/mcpe_pkg.sv -----
// ----------------------------------------------------------------------------
// mcpe_pkg: shared types and control store for the circle point emitter
// Holds the control word layout, the sequencer status bundle, the fixed
// field widths and the control program itself.
// ----------------------------------------------------------------------------
package mcpe_pkg;

  // Fixed field widths.
  localparam int unsigned CenterW = 11;
  localparam int unsigned RadiusW = 6;
  localparam int unsigned PointW  = 13;
  localparam int unsigned DecW    = 10;
  localparam int unsigned OctW    = 3;
  localparam int unsigned TimerW  = 3;

  // Walk constants.
  localparam logic signed [DecW-1:0] DecInit   = 10'sd3;
  localparam logic signed [DecW-1:0] DecIncIn  = 10'sd6;
  localparam logic signed [DecW-1:0] DecIncOut = 10'sd10;
  localparam logic [TimerW-1:0]      EmitSpacing = 3'd5;
  localparam logic [OctW-1:0]        OctLast     = 3'd7;

  // Program counter and step addresses.
  localparam int unsigned UpcW = 3;
  typedef logic [UpcW-1:0] upc_t;

  localparam upc_t UpcIdle     = 3'd0;
  localparam upc_t UpcWalk     = 3'd1;
  localparam upc_t UpcDispatch = 3'd2;
  localparam upc_t UpcEmit     = 3'd3;
  localparam upc_t UpcFinish   = 3'd4;

  // Datapath operation selected by the current control word.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_WALK,
    OP_EMIT,
    OP_FINISH
  } op_e;

  // Jump condition selected by the current control word.
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_IN_VALID,
    COND_WALK_STOP,
    COND_WALK_END,
    COND_GROUP_DONE,
    COND_OUT_FREE
  } cond_e;

  // One control word: operation, jump condition and target, and whether a
  // failed condition falls through to the next step or holds the current one.
  typedef struct packed {
    op_e   op;
    cond_e cond;
    upc_t  target;
    logic  adv;
  } ucode_t;

  // Datapath status that feeds the jump conditions.
  typedef struct packed {
    logic in_valid;
    logic walk_end;
    logic emit_due;
    logic group_done;
    logic out_free;
  } status_t;

  // Control program.
  function automatic ucode_t ucode_rom(upc_t addr);
    ucode_t w;
    case (addr)
      UpcIdle:     w = '{op: OP_LOAD,   cond: COND_IN_VALID,   target: UpcWalk,     adv: 1'b0};
      UpcWalk:     w = '{op: OP_WALK,   cond: COND_WALK_STOP,  target: UpcDispatch, adv: 1'b0};
      UpcDispatch: w = '{op: OP_NONE,   cond: COND_WALK_END,   target: UpcFinish,   adv: 1'b1};
      UpcEmit:     w = '{op: OP_EMIT,   cond: COND_GROUP_DONE, target: UpcWalk,     adv: 1'b0};
      UpcFinish:   w = '{op: OP_FINISH, cond: COND_OUT_FREE,   target: UpcIdle,     adv: 1'b0};
      default:     w = '{op: OP_NONE,   cond: COND_NEVER,      target: UpcIdle,     adv: 1'b0};
    endcase
    return w;
  endfunction

endpackage

// ----- hw/rtl/mcpe_sequencer.sv -----
// ----------------------------------------------------------------------------
// mcpe_sequencer: step counter and control store
// Reads one control word per cycle, evaluates its jump condition against the
// datapath status and hands the selected operation to the datapath.
// ----------------------------------------------------------------------------
module mcpe_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mcpe_pkg::status_t status_i,
  output mcpe_pkg::op_e     op_o
);
  import mcpe_pkg::*;

  upc_t   upc_q, upc_d;
  ucode_t word;
  logic   cond_hit;

  // Fetch the current control word.
  assign word = ucode_rom(upc_q);
  assign op_o = word.op;

  // Condition select.
  always_comb begin
    case (word.cond)
      COND_IN_VALID:   cond_hit = status_i.in_valid;
      COND_WALK_STOP:  cond_hit = status_i.walk_end | status_i.emit_due;
      COND_WALK_END:   cond_hit = status_i.walk_end;
      COND_GROUP_DONE: cond_hit = status_i.group_done;
      COND_OUT_FREE:   cond_hit = status_i.out_free;
      default:         cond_hit = 1'b0;
    endcase
  end

  // Next step: jump, fall through, or hold.
  always_comb begin
    if (cond_hit) begin
      upc_d = word.target;
    end else if (word.adv) begin
      upc_d = upc_q + upc_t'(1);
    end else begin
      upc_d = upc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UpcIdle;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

// ----- hw/rtl/midpoint_circle_point_emitter.sv -----
// ----------------------------------------------------------------------------
// midpoint_circle_point_emitter: midpoint circle walk with eightfold points
// Walks the midpoint circle decision for one centre and radius and sends the
// eight symmetric points of every fifth step, one point per output beat.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload
//  --------  -------------------  -----------------------------------------
//  input     in_valid_i/in_ready_o  center_x_i, center_y_i, circle_radius_i
//  output    out_valid_o/out_ready_i point_x_o, point_y_o, octant_o,
//                                 point_valid_o, last_point_o
//
//  One circle is handled at a time. An item takes an accept step, one walk
//  step per decision update, and per group of eight points a stop step,
//  dispatch, a held point, seven points and a park step (the first group has
//  no held point), then stop, dispatch and finish steps to close; each is a
//  step of the single-issue control sequencer.
//  Reset clears the step counter, the walk state, the octant counter, the
//  held point flag and the output valid flag.
//  The sequencer holds on an emit or finish step while the output register
//  is full and not being taken.
//
module midpoint_circle_point_emitter #(
  parameter int unsigned RADIUS_MAX = 63,
  parameter int unsigned COORD_BITS = 11
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [mcpe_pkg::CenterW-1:0]        center_x_i,
  input  logic [mcpe_pkg::CenterW-1:0]        center_y_i,
  input  logic [mcpe_pkg::RadiusW-1:0]        circle_radius_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [mcpe_pkg::PointW-1:0]  point_x_o,
  output logic signed [mcpe_pkg::PointW-1:0]  point_y_o,
  output logic [mcpe_pkg::OctW-1:0]           octant_o,
  output logic                                point_valid_o,
  output logic                                last_point_o
);
  import mcpe_pkg::*;

  localparam logic [RadiusW-1:0] RadiusMaxC = RadiusW'(RADIUS_MAX);
  localparam logic [CenterW-1:0] CoordMask  =
    (COORD_BITS >= CenterW) ? {CenterW{1'b1}} : CenterW'((1 << COORD_BITS) - 1);

  // Walk state.
  logic [RadiusW-1:0]     x_q, y_q;
  logic signed [DecW-1:0] d_q;
  logic [TimerW-1:0]      timer_q;
  logic [OctW-1:0]        oct_q;
  logic [CenterW-1:0]     cx_q, cy_q;

  // Held eighth point of the latest group.
  logic                   pend_q;
  logic [PointW-1:0]      pend_x_q, pend_y_q;

  // Output register.
  logic                   ovalid_q;
  logic [PointW-1:0]      ox_q, oy_q;
  logic [OctW-1:0]        ooct_q;
  logic                   opvalid_q, olast_q;

  op_e     op;
  status_t status;
  logic    out_free, accept, walk_fire, store_pend, emit_out, finish_out;

  logic [RadiusW-1:0]     r_clamp, a_sel, b_sel;
  logic [PointW-1:0]      pt_x, pt_y;
  logic signed [DecW-1:0] d_inc;
  logic signed [RadiusW:0] xy_diff;

  mcpe_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .op_o     (op)
  );

  // Status toward the sequencer.
  assign out_free = !ovalid_q || out_ready_i;
  always_comb begin
    status.in_valid   = in_valid_i;
    status.walk_end   = !(y_q > x_q);
    status.emit_due   = (timer_q == EmitSpacing);
    status.group_done = (oct_q == OctLast) && !pend_q;
    status.out_free   = out_free;
  end

  // Operation strobes.
  assign in_ready_o = (op == OP_LOAD);
  assign accept     = in_ready_o && in_valid_i;
  assign walk_fire  = (op == OP_WALK) && !(status.walk_end || status.emit_due);
  assign store_pend = (op == OP_EMIT) && status.group_done;
  assign emit_out   = (op == OP_EMIT) && out_free && (pend_q || (oct_q != OctLast));
  assign finish_out = (op == OP_FINISH) && out_free;

  assign r_clamp = (circle_radius_i > RadiusMaxC) ? RadiusMaxC : circle_radius_i;

  // Symmetric point for the current octant.
  always_comb begin
    a_sel = oct_q[0] ? y_q : x_q;
    b_sel = oct_q[0] ? x_q : y_q;
    pt_x  = oct_q[1] ? (PointW'(cx_q) - PointW'(a_sel)) : (PointW'(cx_q) + PointW'(a_sel));
    pt_y  = oct_q[2] ? (PointW'(cy_q) - PointW'(b_sel)) : (PointW'(cy_q) + PointW'(b_sel));
  end

  // Decision increment: 4x + 6 inside, 4(x - y) + 10 outside. The difference
  // is negative or zero, so it is sign extended before the shift.
  always_comb begin
    xy_diff = $signed({1'b0, x_q}) - $signed({1'b0, y_q});
    if (d_q < 0) begin
      d_inc = $signed(DecW'({x_q, 2'b00})) + DecIncIn;
    end else begin
      d_inc = $signed({{(DecW-RadiusW-3){xy_diff[RadiusW]}}, xy_diff, 2'b00})
              + DecIncOut;
    end
  end

  // Walk registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q     <= '0;
      y_q     <= '0;
      d_q     <= '0;
      timer_q <= '0;
      cx_q    <= '0;
      cy_q    <= '0;
    end else if (accept) begin
      x_q     <= '0;
      y_q     <= r_clamp;
      d_q     <= DecInit - $signed(DecW'({r_clamp, 1'b0}));
      timer_q <= '0;
      cx_q    <= center_x_i & CoordMask;
      cy_q    <= center_y_i & CoordMask;
    end else if (walk_fire) begin
      x_q     <= x_q + RadiusW'(1);
      d_q     <= d_q + d_inc;
      timer_q <= timer_q + TimerW'(1);
      if (!(d_q < 0)) begin
        y_q <= y_q - RadiusW'(1);
      end
    end else if (store_pend) begin
      timer_q <= '0;
    end
  end

  // Octant counter and held point flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oct_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      if (accept) begin
        oct_q  <= '0;
        pend_q <= 1'b0;
      end else if (store_pend) begin
        oct_q  <= oct_q + OctW'(1);
        pend_q <= 1'b1;
      end else if (emit_out) begin
        if (pend_q) begin
          pend_q <= 1'b0;
        end else begin
          oct_q <= oct_q + OctW'(1);
        end
      end else if (finish_out) begin
        pend_q <= 1'b0;
      end
    end
  end

  // Held point payload.
  always_ff @(posedge clk_i) begin
    if (store_pend) begin
      pend_x_q <= pt_x;
      pend_y_q <= pt_y;
    end
  end

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (emit_out || finish_out) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  // Output register payload. The held point goes out first; the finish step
  // releases it with the last mark, or sends the empty marker.
  always_ff @(posedge clk_i) begin
    if (emit_out) begin
      opvalid_q <= 1'b1;
      olast_q   <= 1'b0;
      if (pend_q) begin
        ox_q   <= pend_x_q;
        oy_q   <= pend_y_q;
        ooct_q <= OctLast;
      end else begin
        ox_q   <= pt_x;
        oy_q   <= pt_y;
        ooct_q <= oct_q;
      end
    end else if (finish_out) begin
      olast_q <= 1'b1;
      if (pend_q) begin
        opvalid_q <= 1'b1;
        ox_q      <= pend_x_q;
        oy_q      <= pend_y_q;
        ooct_q    <= OctLast;
      end else begin
        opvalid_q <= 1'b0;
        ox_q      <= '0;
        oy_q      <= '0;
        ooct_q    <= '0;
      end
    end
  end

  assign out_valid_o   = ovalid_q;
  assign point_x_o     = $signed(ox_q);
  assign point_y_o     = $signed(oy_q);
  assign octant_o      = ooct_q;
  assign point_valid_o = opvalid_q;
  assign last_point_o  = olast_q;

endmodule

// ----- sim/tb_midpoint_circle_point_emitter.sv -----
// ----------------------------------------------------------------------------
// tb_midpoint_circle_point_emitter: self-checking bench for the point emitter
// Sends circle centres and radii, predicts every emitted point with an
// independent midpoint walk, and checks each output beat in order while both
// channels stall in random bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_midpoint_circle_point_emitter;
  import mcpe_pkg::*;

  localparam int unsigned RadiusMax  = 63;
  localparam int unsigned CoordBits  = 11;
  localparam int unsigned PointLimit = 64;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned DrainWait  = 150;
  localparam int unsigned PrintLimit = 40;
  localparam int unsigned RandomItems = 85;

  // One expected point beat.
  typedef struct packed {
    logic signed [PointW-1:0] px;
    logic signed [PointW-1:0] py;
    logic [OctW-1:0]          oct;
    logic                     pvalid;
    logic                     last;
  } circle_point_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [CenterW-1:0]       center_x = '0;
  logic [CenterW-1:0]       center_y = '0;
  logic [RadiusW-1:0]       circle_radius = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [PointW-1:0] point_x;
  logic signed [PointW-1:0] point_y;
  logic [OctW-1:0]          octant;
  logic                     point_valid;
  logic                     last_point;

  circle_point_t pending_points[$];
  int unsigned   error_count = 0;
  int unsigned   in_idle_pct = 0;
  int unsigned   out_idle_pct = 0;
  int unsigned   out_stall_left = 0;
  int unsigned   quiet_cycles = 0;

  midpoint_circle_point_emitter #(
    .RADIUS_MAX (RadiusMax),
    .COORD_BITS (CoordBits)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .center_x_i      (center_x),
    .center_y_i      (center_y),
    .circle_radius_i (circle_radius),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .point_x_o       (point_x),
    .point_y_o       (point_y),
    .octant_o        (octant),
    .point_valid_o   (point_valid),
    .last_point_o    (last_point)
  );

  // Clock generator.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Prints one mismatch line, quietly once the print budget is spent.
  task automatic report_mismatch(input string msg);
    if (error_count < PrintLimit) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    error_count++;
  endtask

  // Walks the midpoint decision for one circle and queues every point it
  // emits; an empty walk queues a single invalid, last marker.
  function automatic void predict_circle_points(input logic [CenterW-1:0] cx_in,
                                                input logic [CenterW-1:0] cy_in,
                                                input logic [RadiusW-1:0] r_in);
    int            rad;
    int            dec;
    int            wx;
    int            wy;
    int            spacing;
    int            emitted;
    int            a;
    int            b;
    logic [PointW-1:0] cx;
    logic [PointW-1:0] cy;
    circle_point_t pt;
    rad = int'(r_in);
    if (rad > int'(RadiusMax)) begin
      rad = RadiusMax;
    end
    cx = PointW'(int'(cx_in) & ((1 << CoordBits) - 1));
    cy = PointW'(int'(cy_in) & ((1 << CoordBits) - 1));
    dec = 3 - 2 * rad;
    wx = 0;
    wy = rad;
    spacing = 0;
    emitted = 0;
    while (wy > wx) begin
      if (spacing > 4) begin
        if (emitted + 8 <= int'(PointLimit)) begin
          for (int oct = 0; oct < 8; oct++) begin
            a = (oct & 1) ? wy : wx;
            b = (oct & 1) ? wx : wy;
            pt.px = (oct & 2) ? cx - PointW'(a) : cx + PointW'(a);
            pt.py = (oct & 4) ? cy - PointW'(b) : cy + PointW'(b);
            pt.oct = OctW'(oct);
            pt.pvalid = 1'b1;
            pt.last = 1'b0;
            pending_points.push_back(pt);
            emitted++;
          end
        end
        spacing = 0;
      end
      spacing++;
      if (dec < 0) begin
        dec = dec + 4 * wx + 6;
      end else begin
        dec = dec + 4 * (wx - wy) + 10;
        wy--;
      end
      wx++;
    end
    if (emitted == 0) begin
      pt = '{px: '0, py: '0, oct: '0, pvalid: 1'b0, last: 1'b1};
      pending_points.push_back(pt);
    end else begin
      pt = pending_points.pop_back();
      pt.last = 1'b1;
      pending_points.push_back(pt);
    end
  endfunction

  // Sends one circle, optionally after an idle burst, and returns at the
  // edge where the beat is taken. Must be entered at a rising edge.
  task automatic send_circle(input logic [CenterW-1:0] cx,
                             input logic [CenterW-1:0] cy,
                             input logic [RadiusW-1:0] r);
    if (in_idle_pct > 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    center_x      <= cx;
    center_y      <= cy;
    circle_radius <= r;
    do begin
      @(posedge clk_i);
    end while (!(in_valid && in_ready));
    predict_circle_points(cx, cy, r);
  endtask

  // Output ready: random stall bursts.
  always @(posedge clk_i) begin
    if (out_stall_left > 0) begin
      out_ready <= 1'b0;
      out_stall_left <= out_stall_left - 1;
    end else if (out_idle_pct > 0 && $urandom_range(0, 99) < out_idle_pct) begin
      out_ready <= 1'b0;
      out_stall_left <= $urandom_range(0, 4);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result checker: every output beat against the oldest expected point.
  always @(posedge clk_i) begin
    circle_point_t exp_pt;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_points.size() == 0) begin
        report_mismatch($sformatf("unexpected beat x=%0d y=%0d oct=%0d",
                                  point_x, point_y, octant));
      end else begin
        exp_pt = pending_points.pop_front();
        if (point_x !== exp_pt.px) begin
          report_mismatch($sformatf("point_x got %0d want %0d", point_x, exp_pt.px));
        end
        if (point_y !== exp_pt.py) begin
          report_mismatch($sformatf("point_y got %0d want %0d", point_y, exp_pt.py));
        end
        if (octant !== exp_pt.oct) begin
          report_mismatch($sformatf("octant got %0d want %0d", octant, exp_pt.oct));
        end
        if (point_valid !== exp_pt.pvalid) begin
          report_mismatch($sformatf("point_valid got %0b want %0b",
                                    point_valid, exp_pt.pvalid));
        end
        if (last_point !== exp_pt.last) begin
          report_mismatch($sformatf("last_point got %0b want %0b",
                                    last_point, exp_pt.last));
        end
      end
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("[%0t] watchdog: no beat for %0d cycles", $realtime, quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Small radii: the empty marker and the first non-empty walk.
  task automatic test_small_radii();
    for (int r = 0; r <= 8; r++) begin
      send_circle(11'd1024, 11'd1024, RadiusW'(r));
    end
  endtask

  // Centres at the field extremes, largest radius, coordinates below zero
  // and above the centre range.
  task automatic test_field_extremes();
    send_circle(11'd0, 11'd0, 6'd63);
    send_circle(11'd2047, 11'd2047, 6'd63);
    send_circle(11'd0, 11'd2047, 6'd63);
    send_circle(11'd2047, 11'd0, 6'd40);
    send_circle(11'd1365, 11'd682, 6'd42);
    send_circle(11'd682, 11'd1365, 6'd21);
  endtask

  // Random circles with idling on both sides.
  task automatic test_random_circles();
    logic [CenterW-1:0] cx;
    logic [CenterW-1:0] cy;
    logic [RadiusW-1:0] r;
    for (int i = 0; i < int'(RandomItems); i++) begin
      // Vary the idle density so some stretches run with no gaps at all.
      if (i % 30 == 0) begin
        in_idle_pct  = $urandom_range(0, 1) ? 0 : $urandom_range(10, 60);
        out_idle_pct = $urandom_range(0, 1) ? 0 : $urandom_range(5, 40);
      end
      case ($urandom_range(0, 9))
        0, 1:    r = RadiusW'($urandom_range(0, 10));
        2:       r = 6'd63;
        default: r = RadiusW'($urandom);
      endcase
      cx = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 11'd2047 : 11'd0)
                                       : CenterW'($urandom);
      cy = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 11'd2047 : 11'd0)
                                       : CenterW'($urandom);
      send_circle(cx, cy, r);
    end
  endtask

  // Closing stretch: back-to-back circles, no idling on either side.
  task automatic test_back_to_back();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    for (int i = 0; i < 20; i++) begin
      send_circle(CenterW'($urandom), CenterW'($urandom),
                  RadiusW'($urandom_range(0, 63)));
    end
  endtask

  // Test sequence.
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    in_idle_pct  = 30;
    out_idle_pct = 20;
    test_small_radii();
    test_field_extremes();
    test_random_circles();
    test_back_to_back();
    in_valid <= 1'b0;
    while (pending_points.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainWait) @(posedge clk_i);
    if (pending_points.size() != 0) begin
      report_mismatch($sformatf("%0d expected points never arrived",
                                pending_points.size()));
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/mcpe_pkg.sv
hw/rtl/mcpe_sequencer.sv
hw/rtl/midpoint_circle_point_emitter.sv
sim/tb_midpoint_circle_point_emitter.sv
